// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define JTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/jtm_pkg.sv -----
// Types and constants of the joystick to mouse motion block.
package jtm_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int DEFL_BITS    = 7;
  localparam int SPEED_BITS   = 8;
  localparam int DIV_BITS     = 8;
  localparam int INV_BITS     = 2;
  localparam int MOVE_BITS    = 8;
  localparam int MAG_BITS     = 7;
  localparam int FULL_DEFL    = 100;
  localparam int MOVE_LIMIT   = 127;
  localparam int NUM_STAGES   = 7;
  localparam int CFG_IDX_BITS = 3;

  localparam int NUM_BITS   = SAMPLE_BITS + DEFL_BITS;
  localparam int ACC_BITS   = DIV_BITS + DEFL_BITS - 1;
  localparam int DS_BITS    = DEFL_BITS + SPEED_BITS;
  localparam int PROD_BITS  = DS_BITS + DEFL_BITS;
  localparam int SAT_LEVEL  = (MOVE_LIMIT + 1) * FULL_DEFL;
  localparam int QIN_BITS   = $clog2(SAT_LEVEL);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP      = ((1 << RECIP_SHIFT) + FULL_DEFL - 1) / FULL_DEFL;
  localparam int RECIP_BITS = $clog2(RECIP + 1);
  localparam int MUL_BITS   = QIN_BITS + RECIP_BITS;

  localparam logic [SAMPLE_BITS-1:0] MIN_AXIS_RST  = SAMPLE_BITS'(200);
  localparam logic [SAMPLE_BITS-1:0] MAX_AXIS_RST  = SAMPLE_BITS'(820);
  localparam logic [SAMPLE_BITS-1:0] CENTER_RST    = SAMPLE_BITS'(512);
  localparam logic [SPEED_BITS-1:0]  FULL_SPEED_RST = SPEED_BITS'(2);
  localparam logic [SPEED_BITS-1:0]  PREC_SPEED_RST = SPEED_BITS'(1);
  localparam logic [DIV_BITS-1:0]    DIVISOR_RST   = DIV_BITS'(24);
  localparam logic [INV_BITS-1:0]    INVERT_RST    = INV_BITS'(2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_AXIS   = 3'd0,
    REG_MAX_AXIS   = 3'd1,
    REG_X_CENTER   = 3'd2,
    REG_Y_CENTER   = 3'd3,
    REG_FULL_SPEED = 3'd4,
    REG_PREC_SPEED = 3'd5,
    REG_DIVISOR    = 3'd6,
    REG_INVERT     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] min_axis;
    logic [SAMPLE_BITS-1:0] max_axis;
    logic [SAMPLE_BITS-1:0] origin;
    logic [DIV_BITS-1:0]    divisor;
    logic                   invert;
  } axis_cfg_t;

endpackage

// ----- hw/rtl/jtm_axis.sv -----
// Seven-stage datapath for one axis: deflection divide, acceleration divide, scale.
module jtm_axis import jtm_pkg::*; (
  input  logic                        clk,
  input  logic [NUM_STAGES-1:0]       stage_en,
  input  axis_cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0]      sample,
  input  logic [SPEED_BITS-1:0]       speed,
  output logic signed [MOVE_BITS-1:0] move
);

  localparam int HI_STEPS = 3;
  localparam int ACC_HI   = 4;

  // stage 0: distance, span, special cases
  logic                   lo, eq, bad;
  logic [SAMPLE_BITS-1:0] delta, span;
  logic [NUM_BITS-1:0]    s0_num_r;
  logic [SAMPLE_BITS-1:0] s0_span_r;
  logic                   s0_zero_r, s0_full_r, s0_neg_r;
  logic [SPEED_BITS-1:0]  s0_speed_r;

  assign lo    = sample < cfg.origin;
  assign eq    = sample == cfg.origin;
  assign delta = lo ? (cfg.origin - sample) : (sample - cfg.origin);
  assign bad   = lo ? (cfg.origin < cfg.min_axis) : (cfg.max_axis < cfg.origin);
  assign span  = lo ? (cfg.origin - cfg.min_axis) : (cfg.max_axis - cfg.origin);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s0_num_r   <= NUM_BITS'(delta) * NUM_BITS'(FULL_DEFL);
      s0_span_r  <= span;
      s0_zero_r  <= eq || bad;
      s0_full_r  <= (span == '0) || (delta >= span);
      s0_neg_r   <= lo;
      s0_speed_r <= speed;
    end
  end

  // stage 1: upper quotient bits of delta*100/span
  logic [NUM_BITS-1:0]    d1_rem, d1_sh;
  logic [DEFL_BITS-1:0]   d1_q;
  logic [NUM_BITS-1:0]    s1_rem_r;
  logic [DEFL_BITS-1:0]   s1_q_r;
  logic [SAMPLE_BITS-1:0] s1_span_r;
  logic                   s1_zero_r, s1_full_r, s1_neg_r;
  logic [SPEED_BITS-1:0]  s1_speed_r;

  always_comb begin
    d1_rem = s0_num_r;
    d1_q   = '0;
    d1_sh  = '0;
    for (int k = DEFL_BITS - 1; k >= DEFL_BITS - HI_STEPS; k--) begin
      d1_sh = NUM_BITS'(s0_span_r) << k;
      if (d1_rem >= d1_sh) begin
        d1_rem  = d1_rem - d1_sh;
        d1_q[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_rem_r   <= d1_rem;
      s1_q_r     <= d1_q;
      s1_span_r  <= s0_span_r;
      s1_zero_r  <= s0_zero_r;
      s1_full_r  <= s0_full_r;
      s1_neg_r   <= s0_neg_r;
      s1_speed_r <= s0_speed_r;
    end
  end

  // stage 2: lower quotient bits, deflection select
  logic [NUM_BITS-1:0]   d2_rem, d2_sh;
  logic [DEFL_BITS-1:0]  d2_q, defl;
  logic [DEFL_BITS-1:0]  s2_defl_r;
  logic                  s2_neg_r;
  logic [SPEED_BITS-1:0] s2_speed_r;

  always_comb begin
    d2_rem = s1_rem_r;
    d2_q   = s1_q_r;
    d2_sh  = '0;
    for (int k = DEFL_BITS - HI_STEPS - 1; k >= 0; k--) begin
      d2_sh = NUM_BITS'(s1_span_r) << k;
      if (d2_rem >= d2_sh) begin
        d2_rem  = d2_rem - d2_sh;
        d2_q[k] = 1'b1;
      end
    end
    if (s1_zero_r) begin
      defl = '0;
    end else if (s1_full_r) begin
      defl = DEFL_BITS'(FULL_DEFL);
    end else begin
      defl = d2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_defl_r  <= defl;
      s2_neg_r   <= s1_neg_r;
      s2_speed_r <= s1_speed_r;
    end
  end

  // stage 3: upper bits of defl/divisor, defl*speed
  logic [ACC_BITS-1:0]  a3_rem, a3_sh;
  logic [DEFL_BITS-1:0] a3_q;
  logic [DEFL_BITS-1:0] s3_rem_r, s3_q_r;
  logic [DS_BITS-1:0]   s3_ds_r;
  logic                 s3_neg_r;

  always_comb begin
    a3_rem = ACC_BITS'(s2_defl_r);
    a3_q   = '0;
    a3_sh  = '0;
    for (int k = DEFL_BITS - 1; k >= DEFL_BITS - ACC_HI; k--) begin
      a3_sh = ACC_BITS'(cfg.divisor) << k;
      if (a3_rem >= a3_sh) begin
        a3_rem  = a3_rem - a3_sh;
        a3_q[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_rem_r <= a3_rem[DEFL_BITS-1:0];
      s3_q_r   <= a3_q;
      s3_ds_r  <= DS_BITS'(s2_defl_r) * DS_BITS'(s2_speed_r);
      s3_neg_r <= s2_neg_r;
    end
  end

  // stage 4: lower bits of defl/divisor
  logic [ACC_BITS-1:0]  a4_rem, a4_sh;
  logic [DEFL_BITS-1:0] a4_q;
  logic [DEFL_BITS-1:0] s4_accel_r;
  logic [DS_BITS-1:0]   s4_ds_r;
  logic                 s4_neg_r;

  always_comb begin
    a4_rem = ACC_BITS'(s3_rem_r);
    a4_q   = s3_q_r;
    a4_sh  = '0;
    for (int k = DEFL_BITS - ACC_HI - 1; k >= 0; k--) begin
      a4_sh = ACC_BITS'(cfg.divisor) << k;
      if (a4_rem >= a4_sh) begin
        a4_rem  = a4_rem - a4_sh;
        a4_q[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_accel_r <= (cfg.divisor == '0) ? '0 : a4_q;
      s4_ds_r    <= s3_ds_r;
      s4_neg_r   <= s3_neg_r;
    end
  end

  // stage 5: product and saturation detect
  logic [PROD_BITS-1:0] prod;
  logic [QIN_BITS-1:0]  s5_p_r;
  logic                 s5_sat_r, s5_neg_r;

  assign prod = PROD_BITS'(s4_ds_r) * PROD_BITS'(s4_accel_r);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_p_r   <= prod[QIN_BITS-1:0];
      s5_sat_r <= prod >= PROD_BITS'(SAT_LEVEL);
      s5_neg_r <= s4_neg_r;
    end
  end

  // stage 6: divide by 100 via reciprocal, clamp, sign
  logic [MUL_BITS-1:0]  recip_prod;
  logic [MAG_BITS-1:0]  mag;
  logic [MOVE_BITS-1:0] mag_ext;
  logic signed [MOVE_BITS-1:0] move_r;

  assign recip_prod = MUL_BITS'(s5_p_r) * MUL_BITS'(RECIP);
  assign mag     = s5_sat_r ? MAG_BITS'(MOVE_LIMIT)
                            : recip_prod[RECIP_SHIFT+MAG_BITS-1:RECIP_SHIFT];
  assign mag_ext = MOVE_BITS'(mag);

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      move_r <= (s5_neg_r ^ cfg.invert) ? (-mag_ext) : mag_ext;
    end
  end

  assign move = move_r;

endmodule

// ----- hw/rtl/joystick_to_mouse_motion.sv -----
// Joystick ADC pair to signed mouse move: top level with registers and pipeline control.
// One word enters per clock while in_stall is low; the seven-stage datapath
// per axis (two three- and four-step divide sections for the deflection, two
// for the acceleration term, a multiply, a reciprocal multiply by 1/100)
// carries each word to the output. Stages advance independently, so
// bubbles close up and a stalled output stops only the stages behind it.
// Configuration registers are written through cfg_* at any time, always
// ready, and must only change while no word is in flight.
module joystick_to_mouse_motion import jtm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [SAMPLE_BITS-1:0]      in_x_sample,
  input  logic [SAMPLE_BITS-1:0]      in_y_sample,
  input  logic                        in_precision,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [MOVE_BITS-1:0] out_x_move,
  output logic signed [MOVE_BITS-1:0] out_y_move,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [SAMPLE_BITS-1:0]      cfg_data
);

  logic [SAMPLE_BITS-1:0] min_axis_r, max_axis_r, x_center_r, y_center_r;
  logic [SPEED_BITS-1:0]  full_speed_r, prec_speed_r;
  logic [DIV_BITS-1:0]    divisor_r;
  logic [INV_BITS-1:0]    invert_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_axis_r   <= MIN_AXIS_RST;
      max_axis_r   <= MAX_AXIS_RST;
      x_center_r   <= CENTER_RST;
      y_center_r   <= CENTER_RST;
      full_speed_r <= FULL_SPEED_RST;
      prec_speed_r <= PREC_SPEED_RST;
      divisor_r    <= DIVISOR_RST;
      invert_r     <= INVERT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_AXIS:   min_axis_r   <= cfg_data;
        REG_MAX_AXIS:   max_axis_r   <= cfg_data;
        REG_X_CENTER:   x_center_r   <= cfg_data;
        REG_Y_CENTER:   y_center_r   <= cfg_data;
        REG_FULL_SPEED: full_speed_r <= cfg_data[SPEED_BITS-1:0];
        REG_PREC_SPEED: prec_speed_r <= cfg_data[SPEED_BITS-1:0];
        REG_DIVISOR:    divisor_r    <= cfg_data[DIV_BITS-1:0];
        REG_INVERT:     invert_r     <= cfg_data[INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES:0]   stage_rdy;

  always_comb begin
    stage_rdy[NUM_STAGES] = !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_r[k] || stage_rdy[k+1];
    end
    valid_nxt[0] = stage_rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_rdy[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !stage_rdy[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  logic [SPEED_BITS-1:0] speed;
  axis_cfg_t             x_cfg, y_cfg;

  assign speed = in_precision ? prec_speed_r : full_speed_r;

  assign x_cfg = '{min_axis: min_axis_r, max_axis: max_axis_r, origin: x_center_r,
                   divisor: divisor_r, invert: invert_r[0]};
  assign y_cfg = '{min_axis: min_axis_r, max_axis: max_axis_r, origin: y_center_r,
                   divisor: divisor_r, invert: invert_r[1]};

  jtm_axis u_x_axis (
    .clk      (clk),
    .stage_en (stage_rdy[NUM_STAGES-1:0]),
    .cfg      (x_cfg),
    .sample   (in_x_sample),
    .speed    (speed),
    .move     (out_x_move)
  );

  jtm_axis u_y_axis (
    .clk      (clk),
    .stage_en (stage_rdy[NUM_STAGES-1:0]),
    .cfg      (y_cfg),
    .sample   (in_y_sample),
    .speed    (speed),
    .move     (out_y_move)
  );

endmodule

// ----- hw/rtl/jtm_checker.sv -----
// Port-level checker for the joystick to mouse motion block, with its bind.
`include "assert_macros.svh"

module jtm_checker import jtm_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [MOVE_BITS-1:0] out_x_move,
  input logic signed [MOVE_BITS-1:0] out_y_move
);

  `JTM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `JTM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_x_move) && $stable(out_y_move))
  `JTM_ASSERT_NOW(a_move_range, clk, rst_n, out_valid, (out_x_move != -8'sd128) && (out_y_move != -8'sd128))
  `JTM_ASSERT_NOW(a_empty_accepts, clk, rst_n, !out_valid, !in_stall)

endmodule

bind joystick_to_mouse_motion jtm_checker u_jtm_checker (.*);

// ----- tb/tb_joystick_to_mouse_motion.sv -----
// Testbench for joystick_to_mouse_motion: directed and random sample words checked against a local predictor.
`timescale 1ns / 1ps

module tb_joystick_to_mouse_motion;
  import jtm_pkg::*;

  localparam int SMAX = (1 << SAMPLE_BITS) - 1;

  typedef struct {
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic                   precision;
  } joy_word_t;

  typedef struct {
    logic signed [MOVE_BITS-1:0] x_move;
    logic signed [MOVE_BITS-1:0] y_move;
  } move_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_BITS-1:0] in_x_sample = '0;
  logic [SAMPLE_BITS-1:0] in_y_sample = '0;
  logic in_precision = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [MOVE_BITS-1:0] out_x_move;
  logic signed [MOVE_BITS-1:0] out_y_move;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [SAMPLE_BITS-1:0] cfg_data = '0;

  // shadow copy of the register file
  logic [SAMPLE_BITS-1:0] lim_lo = MIN_AXIS_RST;
  logic [SAMPLE_BITS-1:0] lim_hi = MAX_AXIS_RST;
  logic [SAMPLE_BITS-1:0] org_x = CENTER_RST;
  logic [SAMPLE_BITS-1:0] org_y = CENTER_RST;
  logic [SPEED_BITS-1:0] spd_full = FULL_SPEED_RST;
  logic [SPEED_BITS-1:0] spd_prec = PREC_SPEED_RST;
  logic [DIV_BITS-1:0] accel_div = DIVISOR_RST;
  logic [INV_BITS-1:0] inv_mask = INVERT_RST;

  joy_word_t words_todo[$];
  move_t moves_due[$];
  joy_word_t cur;
  move_t due;
  int gap_left = 0;
  int stall_left = 0;
  int hold;
  int errors = 0;
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;

  joystick_to_mouse_motion u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_sample  (in_x_sample),
    .in_y_sample  (in_y_sample),
    .in_precision (in_precision),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x_move   (out_x_move),
    .out_y_move   (out_y_move),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [MOVE_BITS-1:0] axis_move(input logic [SAMPLE_BITS-1:0] pos,
      input logic [SAMPLE_BITS-1:0] org, input logic [SPEED_BITS-1:0] spd, input logic flip);
    int unsigned delta, span, defl, mag;
    logic neg;
    neg = 1'b0;
    defl = 0;
    if (pos < org) begin
      neg = 1'b1;
      delta = org - pos;
      if (org >= lim_lo) begin
        span = org - lim_lo;
        defl = (span == 0) ? FULL_DEFL : delta * FULL_DEFL / span;
      end
    end else if (pos > org) begin
      delta = pos - org;
      if (lim_hi >= org) begin
        span = lim_hi - org;
        defl = (span == 0) ? FULL_DEFL : delta * FULL_DEFL / span;
      end
    end
    if (defl > FULL_DEFL) defl = FULL_DEFL;
    if (defl == 0 || accel_div == 0) return '0;
    mag = defl * spd * (defl / accel_div) / FULL_DEFL;
    if (mag > MOVE_LIMIT) mag = MOVE_LIMIT;
    return (neg != flip) ? MOVE_BITS'(-mag) : MOVE_BITS'(mag);
  endfunction

  function automatic move_t predict_move(input joy_word_t w);
    move_t m;
    logic [SPEED_BITS-1:0] spd;
    spd = w.precision ? spd_prec : spd_full;
    m.x_move = axis_move(w.x_sample, org_x, spd, inv_mask[0]);
    m.y_move = axis_move(w.y_sample, org_y, spd, inv_mask[1]);
    return m;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] org);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, SMAX);
      3: v = org;
      4: v = int'(org) + int'($urandom_range(0, 2)) - 1;
      5: v = $urandom_range(0, 1) ? int'(lim_lo) : int'(lim_hi);
      6: v = $urandom_range(0, 1) ? 0 : SMAX;
      default: v = int'(org) + int'($urandom_range(0, 400)) - 200;
    endcase
    if (v < 0) v = 0;
    if (v > SMAX) v = SMAX;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic add_word(input int unsigned x, input int unsigned y, input bit p);
    joy_word_t w;
    w.x_sample = SAMPLE_BITS'(x);
    w.y_sample = SAMPLE_BITS'(y);
    w.precision = p;
    words_todo.push_back(w);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned v);
    logic [SAMPLE_BITS-1:0] data;
    data = SAMPLE_BITS'(v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_AXIS:   lim_lo = data;
      REG_MAX_AXIS:   lim_hi = data;
      REG_X_CENTER:   org_x = data;
      REG_Y_CENTER:   org_y = data;
      REG_FULL_SPEED: spd_full = data[SPEED_BITS-1:0];
      REG_PREC_SPEED: spd_prec = data[SPEED_BITS-1:0];
      REG_DIVISOR:    accel_div = data[DIV_BITS-1:0];
      REG_INVERT:     inv_mask = data[INV_BITS-1:0];
      default: ;
    endcase
  endtask

  // wait until the pipeline is empty, plus its latency
  task automatic drain();
    while (words_todo.size() != 0 || in_valid || moves_due.size() != 0) @(negedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
  endtask

  // word source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.x_sample = in_x_sample;
        cur.y_sample = in_y_sample;
        cur.precision = in_precision;
        moves_due.push_back(predict_move(cur));
      end
      if (in_valid && in_stall) begin
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (words_todo.size() != 0) begin
        cur = words_todo.pop_front();
        in_x_sample <= cur.x_sample;
        in_y_sample <= cur.y_sample;
        in_precision <= cur.precision;
        in_valid <= 1'b1;
        gap_left <= src_gaps_on ? $urandom_range(0, 5) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        if (moves_due.size() == 0) begin
          $error("result word with nothing expected: x_move %0d y_move %0d",
                 out_x_move, out_y_move);
          errors++;
        end else begin
          due = moves_due.pop_front();
          if (out_x_move !== due.x_move) begin
            $error("x_move expected %0d got %0d", due.x_move, out_x_move);
            errors++;
          end
          if (out_y_move !== due.y_move) begin
            $error("y_move expected %0d got %0d", due.y_move, out_y_move);
            errors++;
          end
        end
        hold = sink_stalls_on ? $urandom_range(0, 5) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  initial begin
    int unsigned lo, hi;
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: origin, rails, limits, one step off origin, bit patterns
    add_word(512, 512, 0);
    add_word(0, SMAX, 0);
    add_word(SMAX, 0, 1);
    add_word(200, 820, 0);
    add_word(820, 200, 1);
    add_word(511, 513, 0);
    add_word(10'h155, 10'h2AA, 0);
    add_word(10'h2AA, 10'h155, 1);
    drain();

    // widest spans, top speed, divisor 1, both axes inverted
    write_reg(REG_MIN_AXIS, 0);
    write_reg(REG_MAX_AXIS, SMAX);
    write_reg(REG_X_CENTER, 0);
    write_reg(REG_Y_CENTER, SMAX);
    write_reg(REG_FULL_SPEED, SMAX);
    write_reg(REG_PREC_SPEED, 10'h300);
    write_reg(REG_DIVISOR, 1);
    write_reg(REG_INVERT, 3);
    add_word(SMAX, 0, 0);
    add_word(0, SMAX, 0);
    add_word(512, 511, 0);
    add_word(SMAX, 0, 1);
    drain();

    // origin on the low limit (zero span) and above the high limit (wrong side)
    write_reg(REG_MIN_AXIS, 300);
    write_reg(REG_MAX_AXIS, 700);
    write_reg(REG_X_CENTER, 300);
    write_reg(REG_Y_CENTER, 800);
    write_reg(REG_FULL_SPEED, 10);
    write_reg(REG_INVERT, 0);
    add_word(299, 900, 0);
    add_word(0, 100, 0);
    add_word(301, 799, 0);
    add_word(700, SMAX, 0);
    drain();

    // divisor of zero after masking
    write_reg(REG_DIVISOR, 10'h300);
    add_word(0, 100, 0);
    add_word(SMAX, 0, 1);
    drain();

    for (int p = 0; p < 13; p++) begin
      if ($urandom_range(0, 3) != 0) begin
        lo = $urandom_range(0, 450);
        hi = $urandom_range(574, SMAX);
        write_reg(REG_MIN_AXIS, lo);
        write_reg(REG_MAX_AXIS, hi);
        write_reg(REG_X_CENTER, $urandom_range(lo, hi));
        write_reg(REG_Y_CENTER, $urandom_range(lo, hi));
        write_reg(REG_FULL_SPEED, $urandom_range(0, 40) + ($urandom_range(0, 3) << 8));
        write_reg(REG_PREC_SPEED, $urandom_range(0, 10) + ($urandom_range(0, 3) << 8));
        write_reg(REG_DIVISOR, $urandom_range(1, 60) + ($urandom_range(0, 3) << 8));
        write_reg(REG_INVERT, $urandom_range(0, SMAX));
      end else begin
        for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), $urandom_range(0, SMAX));
      end
      mode = (p == 0) ? 3 : (p == 1) ? 0 : $urandom_range(0, 3);
      src_gaps_on = mode[0];
      sink_stalls_on = mode[1];
      repeat (150) add_word(pick_sample(org_x), pick_sample(org_y), $urandom_range(0, 1));
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- joystick_to_mouse_motion.f -----
+incdir+hw/rtl
hw/rtl/jtm_pkg.sv
hw/rtl/jtm_axis.sv
hw/rtl/joystick_to_mouse_motion.sv
hw/rtl/jtm_checker.sv
tb/tb_joystick_to_mouse_motion.sv
